@@ rtl/prime_counter_trial_division_assert.svh @@
// assertion helpers for the prime counter
`ifndef PRIME_COUNTER_TRIAL_DIVISION_ASSERT_SVH
`define PRIME_COUNTER_TRIAL_DIVISION_ASSERT_SVH
`ifndef SYNTHESIS
`define PCTD_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
`define PCTD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define PCTD_ASSERT_NOW(label, clk, rst, cond, expr)
`define PCTD_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

@@ rtl/pctd_pkg.sv @@
`timescale 1ns / 1ps
package pctd_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int LIMIT_BITS     = 32;
   localparam int COUNT_BITS     = 27;

   typedef struct packed {
      logic load;
      logic cand_start;
      logic prime;
      logic composite;
      logic div_start;
      logic div_step;
      logic div_next;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic lim_small;
      logic cand_done;
      logic sq_gt;
      logic div_done;
      logic rem_zero;
   } status_type;

endpackage

@@ rtl/pctd_ctrl.sv @@
`timescale 1ns / 1ps
module pctd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  pctd_pkg::status_type status,
   output pctd_pkg::cmd_type    cmd
);
   import pctd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CAND = 5'b00010,
      S_TEST = 5'b00100,
      S_DIV  = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.lim_small ? S_FIN : S_CAND;
            end
         end
         S_CAND: begin
            if (status.cand_done) begin
               state_in = S_FIN;
            end else begin
               cmd.cand_start = 1'b1;
               state_in       = S_TEST;
            end
         end
         S_TEST: begin
            if (status.sq_gt) begin
               cmd.prime = 1'b1;
               state_in  = S_CAND;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (!status.div_done) begin
               cmd.div_step = 1'b1;
            end else if (status.rem_zero) begin
               cmd.composite = 1'b1;
               state_in      = S_CAND;
            end else begin
               cmd.div_next = 1'b1;
               state_in     = S_TEST;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/pctd_datapath.sv @@
`timescale 1ns / 1ps
module pctd_datapath #(
   parameter int VALUE_BITS = pctd_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic [pctd_pkg::LIMIT_BITS-1:0]  req_limit,
   input  pctd_pkg::cmd_type                cmd,
   output pctd_pkg::status_type             status,
   output logic [pctd_pkg::COUNT_BITS-1:0]  rsp_prime_count
);
   import pctd_pkg::*;

   localparam int DW  = VALUE_BITS / 2 + 2;   // divisor width
   localparam int SQW = VALUE_BITS + 1;       // divisor square width
   localparam int CW  = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] limit_ff, limit_in;
   logic [VALUE_BITS-1:0] cand_ff, cand_in;
   logic [DW-1:0]         div_ff, div_in;
   logic [SQW-1:0]        sq_ff, sq_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [VALUE_BITS-1:0] dvd_ff, dvd_in;
   logic [DW-1:0]         rem_ff, rem_in;
   logic [CW-1:0]         step_ff, step_in;
   logic [COUNT_BITS-1:0] out_ff, out_in;
   logic [VALUE_BITS-1:0] lim_low;
   logic [DW:0]           trial;
   logic [DW:0]           trial_diff;

   assign lim_low    = req_limit[VALUE_BITS-1:0];
   assign trial      = {rem_ff, dvd_ff[VALUE_BITS-1]};
   assign trial_diff = trial - {1'b0, div_ff};

   assign status.lim_small = lim_low[VALUE_BITS-1] || (lim_low < VALUE_BITS'(3));
   assign status.cand_done = (cand_ff >= limit_ff);
   assign status.sq_gt     = (sq_ff > {1'b0, cand_ff});
   assign status.div_done  = (step_ff == CW'(VALUE_BITS));
   assign status.rem_zero  = (rem_ff == '0);

   always_comb begin
      limit_in = limit_ff;
      cand_in  = cand_ff;
      div_in   = div_ff;
      sq_in    = sq_ff;
      count_in = count_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      out_in   = out_ff;
      if (cmd.load) begin
         limit_in = lim_low;
         cand_in  = VALUE_BITS'(3);
         count_in = status.lim_small ? '0 : COUNT_BITS'(1);
      end
      if (cmd.cand_start) begin
         div_in = DW'(3);
         sq_in  = SQW'(9);
      end
      if (cmd.prime) begin
         count_in = count_ff + COUNT_BITS'(1);
         cand_in  = cand_ff + VALUE_BITS'(2);
      end
      if (cmd.composite) begin
         cand_in = cand_ff + VALUE_BITS'(2);
      end
      if (cmd.div_start) begin
         dvd_in  = cand_ff;
         rem_in  = '0;
         step_in = '0;
      end
      if (cmd.div_step) begin
         // one restoring step: bring down the next bit of the candidate
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial_diff[DW-1:0];
         end else begin
            rem_in = trial[DW-1:0];
         end
         dvd_in  = {dvd_ff[VALUE_BITS-2:0], 1'b0};
         step_in = step_ff + CW'(1);
      end
      if (cmd.div_next) begin
         // (d+2)^2 = d^2 + 4d + 4
         div_in = div_ff + DW'(2);
         sq_in  = sq_ff + (SQW'(div_ff) << 2) + SQW'(4);
      end
      if (cmd.out_load) begin
         out_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
      cand_ff  <= cand_in;
      div_ff   <= div_in;
      sq_ff    <= sq_in;
      count_ff <= count_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      out_ff   <= out_in;
   end

   assign rsp_prime_count = out_ff;

endmodule

@@ rtl/prime_counter_trial_division.sv @@
`timescale 1ns / 1ps
// channel  direction  handshake             word
// req      in         req_valid/req_stall   req_limit (32 bits, signed)
// rsp      out        rsp_valid/rsp_stall   rsp_prime_count (27 bits)
//
// one limit at a time; a limit below three goes from idle straight to the result
// otherwise each odd candidate passes the candidate and test states, plus a pass of
// the bit-serial remainder unit over all VALUE_BITS bits per trial divisor, which sets the rate
// synchronous active-high reset clears the controller and the result valid only
// a new limit is taken while the previous count still waits in the output register
module prime_counter_trial_division #(
   parameter int VALUE_BITS = pctd_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pctd_pkg::LIMIT_BITS-1:0] req_limit,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pctd_pkg::COUNT_BITS-1:0] rsp_prime_count
);
   import pctd_pkg::*;

   `include "prime_counter_trial_division_assert.svh"

   cmd_type    cmd;
   status_type status;

   // sequencer: candidate loop, divisor loop, result handshake
   pctd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // candidate, divisor, running square, remainder unit and count
   pctd_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock           (clock),
      .req_limit       (req_limit),
      .cmd             (cmd),
      .status          (status),
      .rsp_prime_count (rsp_prime_count)
   );

   // once a limit is taken the block is busy in the following cycle
   `PCTD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // a fresh result always comes with the block back at rest
   `PCTD_ASSERT_NOW(a_idle_on_result, clock, reset, $rose(rsp_valid), !req_stall)
   // the remainder unit is only stepped while it has bits left
   `PCTD_ASSERT_NOW(a_step_in_range, clock, reset, cmd.div_step, !status.div_done)

endmodule

@@ bench/prime_counter_trial_division_tb.sv @@
`timescale 1ns / 1ps
module prime_counter_trial_division_tb;
   import pctd_pkg::*;

   // the counter is slow, since every odd candidate is trial divided bit-serially,
   // so positive limits stay small and only one limit near a thousand is used
   localparam int VALUE_BITS    = VALUE_BITS_DEF;
   localparam int RANDOM_LIMITS = 78;
   localparam int QUIET_TAIL    = 15;
   localparam int PAUSE_AT      = 40;
   localparam int PLAN_ROWS     = 22;
   localparam int DRAIN_CYCLES  = 64;
   localparam int CYCLE_LIMIT   = 20_000_000;

   typedef logic [COUNT_BITS-1:0] count_type;

   // one row of the directed table: a limit, and a count typed in by hand where
   // it is plain to see, otherwise the count comes from the predictor
   typedef struct packed {
      logic [LIMIT_BITS-1:0] limit;
      logic                  typed_in;
      count_type             count;
   } plan_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [LIMIT_BITS-1:0] req_limit = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   count_type             rsp_prime_count;

   count_type counts_due[$];
   int        mismatches = 0;
   int        cycles     = 0;
   int        stall_left = 0;
   bit        quiet      = 1'b0;

   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{32'h8000_0000, 1'b1, 27'd0},   // most negative limit
      '{32'hFFFF_FFFF, 1'b1, 27'd0},   // minus one
      '{32'hFFFF_FFFD, 1'b1, 27'd0},
      '{32'h8000_0003, 1'b1, 27'd0},   // negative, low bits look like three
      '{32'hD555_5555, 1'b1, 27'd0},
      '{32'd0,         1'b1, 27'd0},
      '{32'd1,         1'b1, 27'd0},
      '{32'd2,         1'b1, 27'd0},   // two itself is not below two
      '{32'd3,         1'b1, 27'd1},   // smallest limit that counts anything
      '{32'd4,         1'b1, 27'd2},
      '{32'd5,         1'b1, 27'd2},
      '{32'd6,         1'b1, 27'd3},
      '{32'd7,         1'b1, 27'd3},
      '{32'd8,         1'b1, 27'd4},
      '{32'd9,         1'b1, 27'd4},   // first odd composite sits at the limit
      '{32'd10,        1'b1, 27'd4},
      '{32'd25,        1'b0, 27'd0},   // square of a prime sits at the limit
      '{32'd26,        1'b0, 27'd0},   // and now just below it
      '{32'd100,       1'b1, 27'd25},
      '{32'd121,       1'b0, 27'd0},
      '{32'd122,       1'b0, 27'd0},
      '{32'd1024,      1'b0, 27'd0}    // longest run of the whole test
   };

   prime_counter_trial_division #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_limit      (req_limit),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_count(rsp_prime_count)
   );

   always #10 clock = ~clock;

   // primes strictly below the limit, by plain trial division with a wide square
   function automatic count_type primes_below(input logic [LIMIT_BITS-1:0] raw);
      logic signed [LIMIT_BITS-1:0] n;
      longint                       cand;
      longint                       div;
      bit                           is_prime;
      count_type                    total;
      // only the low VALUE_BITS bits count, sign-extended from the top one
      n = raw << (LIMIT_BITS - VALUE_BITS);
      n = n >>> (LIMIT_BITS - VALUE_BITS);
      total = '0;
      if (n >= 3) begin
         total = count_type'(1);   // the prime two
         for (cand = 3; cand < longint'(n); cand += 2) begin
            is_prime = 1'b1;
            for (div = 2; is_prime && div * div <= cand; div++)
               if (cand % div == 0) is_prime = 1'b0;
            if (is_prime) total++;
         end
      end
      return total;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      mismatches++;
   endtask

   // present one limit, with an occasional idle burst first, and hold it until taken
   task automatic offer_limit(input logic [LIMIT_BITS-1:0] value, input logic typed_in,
                              input count_type typed_count);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_limit <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      counts_due.push_back(typed_in ? typed_count : primes_below(value));
   endtask

   // random limit: mostly small positive ones, some at or below two, some negative
   function automatic logic [LIMIT_BITS-1:0] pick_limit();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12)
         return $urandom | 32'h8000_0000;
      else if (pick < 18)
         return $urandom_range(0, 2);
      else if (pick < 95)
         return $urandom_range(3, 200);
      else
         return $urandom_range(201, 512);
   endfunction

   // sender: reset, directed table, random limits, then drain
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i])
         offer_limit(directed_plan[i].limit, directed_plan[i].typed_in,
                     directed_plan[i].count);

      for (int k = 0; k < RANDOM_LIMITS; k++) begin
         if (k == PAUSE_AT) begin
            // hold off until every outstanding count is back
            req_valid <= 1'b0;
            @(posedge clock);
            while (counts_due.size() != 0) @(posedge clock);
         end
         if (k == RANDOM_LIMITS - QUIET_TAIL) quiet = 1'b1;
         offer_limit(pick_limit(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (counts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // receiver: check every accepted word, then decide the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (counts_due.size() == 0)
               report_mismatch($sformatf("count %0d with nothing outstanding",
                                         rsp_prime_count));
            else if (rsp_prime_count !== counts_due[0])
               report_mismatch($sformatf("count %0d, predicted %0d",
                                         rsp_prime_count, counts_due.pop_front()));
            else
               void'(counts_due.pop_front());
         end
         if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog, well above the slowest correct run
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
